@@ src/wbps_pkg.sv @@
// Shared constants and register map for the wildcard byte pattern scanner.
`default_nettype none

package wbps_pkg;

  localparam int PATTERN_MAX_DEF   = 16;
  localparam int POSITION_BITS_DEF = 32;
  localparam int PAT_BYTES         = 16;
  localparam int LEN_W             = 5;
  localparam int INDEX_W           = 32;
  localparam int OFFSET_W          = 34;
  localparam int APB_DATA_W        = 64;
  localparam int APB_ADDR_W        = 6;
  localparam int TDATA_IN_W        = 8;
  localparam int TDATA_OUT_W       = 72;

  typedef enum logic [2:0] {
    REG_PATTERN_LOW     = 3'd0,
    REG_PATTERN_HIGH    = 3'd1,
    REG_PATTERN_LENGTH  = 3'd2,
    REG_WILDCARD_BYTE   = 3'd3,
    REG_SEARCH_COUNT    = 3'd4,
    REG_REVERSE_MODE    = 3'd5,
    REG_RELATIVE_OFFSET = 3'd6
  } cfg_reg_t;

endpackage

`default_nettype wire

@@ src/wildcard_byte_pattern_scanner.sv @@
// Wildcard byte pattern scanner: history shift register, parallel comparators, result register.
// Path of a beat: history and stage-1 registers, then the result register.
// Throughput: one input beat per cycle unless the output stalls; the comparator bank over
// the history register checks the window ending at each byte in the cycle after it is taken.
// Reset (rst, synchronous): clears registers to their defaults, the history, the
// position and the done flag, and empties both pipeline stages.
`default_nettype none

module wildcard_byte_pattern_scanner #(
  parameter int PATTERN_MAX   = wbps_pkg::PATTERN_MAX_DEF,
  parameter int POSITION_BITS = wbps_pkg::POSITION_BITS_DEF
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 s_tvalid,
  output logic                                s_tready,
  input  wire  [wbps_pkg::TDATA_IN_W-1:0]     s_tdata,   // [7:0] data_byte
  input  wire                                 s_tlast,   // last_byte
  output logic                                m_tvalid,
  input  wire                                 m_tready,
  output logic [wbps_pkg::TDATA_OUT_W-1:0]    m_tdata,   // [31:0] found_index,
                                                         // [65:32] address_offset, [71:66] zero
  output logic                                m_tuser,   // match_found
  input  wire                                 psel,
  input  wire                                 penable,
  input  wire                                 pwrite,
  input  wire  [wbps_pkg::APB_ADDR_W-1:0]     paddr,
  input  wire  [wbps_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [wbps_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready
);
  import wbps_pkg::*;

  localparam int POS_W   = POSITION_BITS + 1;
  localparam int IDX_EXT = (POSITION_BITS > OFFSET_W) ? POSITION_BITS : OFFSET_W;

  logic [63:0]              pattern_low;
  logic [63:0]              pattern_high;
  logic [LEN_W-1:0]         pattern_length;
  logic [7:0]               wildcard_byte;
  logic [31:0]              search_count;
  logic                     reverse_mode;
  logic [31:0]              relative_offset;

  logic [7:0]               hist [PATTERN_MAX];
  logic [POS_W-1:0]         pos;
  logic                     s1_valid;
  logic                     s1_last;
  logic [POS_W-1:0]         s1_pos;
  logic                     done;
  logic                     out_valid;
  logic                     out_found;
  logic [INDEX_W-1:0]       out_index;
  logic [OFFSET_W-1:0]      out_offset;

  logic                     cfg_write;
  cfg_reg_t                 cfg_sel;
  logic                     s_accept;
  logic [7:0]               pat [PATTERN_MAX];
  logic [PATTERN_MAX:0]     hit_by_len;
  logic [LEN_W-1:0]         len;
  logic                     win_hit;
  logic [POS_W-1:0]         len_m1;
  logic [POS_W-1:0]         start;
  logic [POSITION_BITS-1:0] size;
  logic                     in_range;
  logic                     hit;
  logic                     produce;
  logic                     s1_go;
  logic [POSITION_BITS-1:0] idx;
  logic [IDX_EXT-1:0]       idx_w;
  logic [OFFSET_W-1:0]      sum;
  logic [OFFSET_W-1:0]      ofs;

  // configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;
  assign cfg_sel   = cfg_reg_t'(paddr[APB_ADDR_W-1:3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low     <= '0;
      pattern_high    <= '0;
      pattern_length  <= LEN_W'(1);
      wildcard_byte   <= '0;
      search_count    <= '0;
      reverse_mode    <= 1'b0;
      relative_offset <= '0;
    end else if (cfg_write) begin
      case (cfg_sel)
        REG_PATTERN_LOW:     pattern_low     <= pwdata;
        REG_PATTERN_HIGH:    pattern_high    <= pwdata;
        REG_PATTERN_LENGTH:  pattern_length  <= pwdata[LEN_W-1:0];
        REG_WILDCARD_BYTE:   wildcard_byte   <= pwdata[7:0];
        REG_SEARCH_COUNT:    search_count    <= pwdata[31:0];
        REG_REVERSE_MODE:    reverse_mode    <= pwdata[0];
        REG_RELATIVE_OFFSET: relative_offset <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      REG_PATTERN_LOW:     prdata = pattern_low;
      REG_PATTERN_HIGH:    prdata = pattern_high;
      REG_PATTERN_LENGTH:  prdata = {{(APB_DATA_W-LEN_W){1'b0}}, pattern_length};
      REG_WILDCARD_BYTE:   prdata = {56'd0, wildcard_byte};
      REG_SEARCH_COUNT:    prdata = {32'd0, search_count};
      REG_REVERSE_MODE:    prdata = {63'd0, reverse_mode};
      REG_RELATIVE_OFFSET: prdata = {32'd0, relative_offset};
      default:             prdata = '0;
    endcase
  end

  // input stage: history shift register and byte position
  assign s_accept = s_tvalid & s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < PATTERN_MAX; k++) begin
        hist[k] <= '0;
      end
      pos      <= '0;
      s1_valid <= 1'b0;
      s1_last  <= 1'b0;
      s1_pos   <= '0;
    end else begin
      if (s_accept) begin
        for (int k = PATTERN_MAX - 1; k > 0; k--) begin
          hist[k] <= s1_last ? 8'd0 : hist[k-1];
        end
        hist[0]  <= s_tdata[7:0];
        s1_last  <= s_tlast;
        s1_pos   <= pos;
        if (s_tlast) begin
          pos <= '0;
        end else if (pos != {POS_W{1'b1}}) begin
          pos <= pos + POS_W'(1);
        end
      end
      if (s_accept) begin
        s1_valid <= 1'b1;
      end else if (s1_go) begin
        s1_valid <= 1'b0;
      end
    end
  end

  // comparator bank
  always_comb begin
    for (int j = 0; j < PATTERN_MAX; j++) begin
      if (j < PAT_BYTES / 2) begin
        pat[j] = pattern_low[8*j +: 8];
      end else if (j < PAT_BYTES) begin
        pat[j] = pattern_high[8*(j-PAT_BYTES/2) +: 8];
      end else begin
        pat[j] = 8'd0;
      end
    end
  end

  always_comb begin
    hit_by_len[0] = 1'b0;
    for (int l = 1; l <= PATTERN_MAX; l++) begin
      hit_by_len[l] = 1'b1;
      for (int j = 0; j < l; j++) begin
        if (pat[j] != wildcard_byte && pat[j] != hist[l-1-j]) begin
          hit_by_len[l] = 1'b0;
        end
      end
    end
  end

  always_comb begin
    if (int'(pattern_length) > PATTERN_MAX) begin
      len = LEN_W'(PATTERN_MAX);
    end else begin
      len = pattern_length;
    end
    win_hit = 1'b0;
    for (int l = 1; l <= PATTERN_MAX; l++) begin
      if (int'(len) == l) begin
        win_hit = hit_by_len[l];
      end
    end
  end

  assign size     = POSITION_BITS'(search_count);
  assign len_m1   = POS_W'(len) - POS_W'(1);
  assign start    = s1_pos - len_m1;
  assign in_range = reverse_mode ? (start <= {1'b0, size}) : (start < {1'b0, size});
  assign hit      = !done && (len != '0) && (size != '0) && (s1_pos >= len_m1)
                    && in_range && win_hit;
  assign produce  = hit || (s1_last && !done);
  assign s1_go    = s1_valid && (!produce || !out_valid || m_tready);
  assign s_tready = !s1_valid || s1_go;

  assign idx   = reverse_mode ? (size - start[POSITION_BITS-1:0]) : start[POSITION_BITS-1:0];
  assign idx_w = IDX_EXT'(idx);
  assign sum   = idx_w[OFFSET_W-1:0] + OFFSET_W'(relative_offset);
  assign ofs   = reverse_mode ? (OFFSET_W'(0) - sum) : sum;

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_go) begin
        done <= s1_last ? 1'b0 : (done | hit);
      end
      if (s1_go && produce) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && produce) begin
      out_found  <= hit;
      out_index  <= hit ? idx_w[INDEX_W-1:0] : '0;
      out_offset <= hit ? ofs : '0;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_found;
  assign m_tdata  = {{(TDATA_OUT_W-INDEX_W-OFFSET_W){1'b0}}, out_offset, out_index};

endmodule

`default_nettype wire

@@ test/wildcard_byte_pattern_scanner_tb.sv @@
// Self-checking testbench for the wildcard byte pattern scanner: directed and random byte streams.
`timescale 1ns / 100ps

module wildcard_byte_pattern_scanner_tb;
  import wbps_pkg::*;

  localparam int ITEMS     = 1200;
  localparam int LIMIT     = 200000;
  localparam int HOLD_LEN  = 300;
  localparam int IDLE_PCT  = 13;

  typedef struct {
    logic        found;
    logic [31:0] index;
    logic [33:0] offset;
  } scan_hit_t;

  class scan_checker;
    logic [63:0] pat_lo, pat_hi;
    logic [4:0]  pat_len;
    logic [7:0]  wild;
    logic [31:0] size;
    logic        rev;
    logic [31:0] rel_ofs;
    logic [7:0]  hist [16];
    logic [32:0] pos;
    bit          done;
    scan_hit_t   pending_hits [$];
    int          errors;

    function new();
      pat_lo = '0;
      pat_hi = '0;
      pat_len = 5'd1;
      wild = '0;
      size = '0;
      rev = 1'b0;
      rel_ofs = '0;
      errors = 0;
      rearm();
    endfunction

    function void rearm();
      for (int k = 0; k < 16; k++) hist[k] = 8'h00;
      pos = '0;
      done = 1'b0;
    endfunction

    function void set_reg(cfg_reg_t r, logic [63:0] v);
      case (r)
        REG_PATTERN_LOW:     pat_lo = v;
        REG_PATTERN_HIGH:    pat_hi = v;
        REG_PATTERN_LENGTH:  pat_len = v[4:0];
        REG_WILDCARD_BYTE:   wild = v[7:0];
        REG_SEARCH_COUNT:    size = v[31:0];
        REG_REVERSE_MODE:    rev = v[0];
        REG_RELATIVE_OFFSET: rel_ofs = v[31:0];
        default: ;
      endcase
    endfunction

    function logic [7:0] pattern_byte(int j);
      if (j < 8) return pat_lo[8*j +: 8];
      return pat_hi[8*(j-8) +: 8];
    endfunction

    function void take_byte(logic [7:0] b, logic last);
      int          len;
      logic [32:0] start;
      logic [7:0]  p;
      logic [33:0] sum;
      bit          hit;
      scan_hit_t   h;
      len = (pat_len > 16) ? 16 : int'(pat_len);
      for (int k = 15; k > 0; k--) hist[k] = hist[k-1];
      hist[0] = b;
      if (!done && len > 0 && size != 0 && pos >= 33'(len - 1)) begin
        start = pos - 33'(len - 1);
        if (rev ? (start <= {1'b0, size}) : (start < {1'b0, size})) begin
          hit = 1'b1;
          for (int j = 0; j < len; j++) begin
            p = pattern_byte(j);
            if (p != wild && p != hist[len-1-j]) hit = 1'b0;
          end
          if (hit) begin
            h.found = 1'b1;
            h.index = rev ? (size - start[31:0]) : start[31:0];
            sum = {2'b00, h.index} + {2'b00, rel_ofs};
            h.offset = rev ? (34'd0 - sum) : sum;
            pending_hits.push_back(h);
            done = 1'b1;
          end
        end
      end
      if (last) begin
        if (!done) begin
          h.found = 1'b0;
          h.index = '0;
          h.offset = '0;
          pending_hits.push_back(h);
        end
        rearm();
      end else if (pos != '1) begin
        pos++;
      end
    endfunction

    function void check_hit(logic found, logic [31:0] index, logic [33:0] offset);
      scan_hit_t e;
      if (pending_hits.size() == 0) begin
        $error("unexpected result beat: match_found %0b found_index %0d address_offset %h",
               found, index, offset);
        errors++;
        return;
      end
      e = pending_hits.pop_front();
      if (found !== e.found) begin
        $error("match_found: expected %0b, actual %0b", e.found, found);
        errors++;
      end
      if (index !== e.index) begin
        $error("found_index: expected %0d, actual %0d", e.index, index);
        errors++;
      end
      if (offset !== e.offset) begin
        $error("address_offset: expected %h, actual %h", e.offset, offset);
        errors++;
      end
    endfunction
  endclass

  logic                     clk;
  logic                     rst;
  logic                     s_tvalid;
  logic                     s_tready;
  logic [TDATA_IN_W-1:0]    s_tdata;   // [7:0] data_byte
  logic                     s_tlast;   // last_byte
  logic                     m_tvalid;
  logic                     m_tready;
  logic [TDATA_OUT_W-1:0]   m_tdata;   // [31:0] found_index, [65:32] address_offset, [71:66] zero
  logic                     m_tuser;   // match_found
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [APB_ADDR_W-1:0]    paddr;
  logic [APB_DATA_W-1:0]    pwdata;
  logic [APB_DATA_W-1:0]    prdata;
  logic                     pready;

  scan_checker sb;
  bit          calm = 1'b0;
  int          hold_go = 0;
  int          bytes_sent = 0;
  logic [7:0]  stream_buf [64];
  logic [127:0] cur_pat;
  logic [4:0]  cur_len;
  logic [7:0]  cur_wild;

  wildcard_byte_pattern_scanner dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : watchdog
    repeat (LIMIT) @(posedge clk);
    $display("Verification failed");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.take_byte(s_tdata, s_tlast);
      if (m_tvalid && m_tready) sb.check_hit(m_tuser, m_tdata[31:0], m_tdata[65:32]);
    end
  end

  initial begin : receiver
    int left;
    int served;
    left = 0;
    served = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (served < hold_go) begin
        served++;
        left = HOLD_LEN;
      end
      if (left > 0) begin
        left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    @(negedge clk);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tlast <= last;
    bytes_sent++;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (sb.pending_hits.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic reg_write(input cfg_reg_t r, input logic [63:0] v);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {r, 3'b000};
    pwdata <= v;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(r, v);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_config(input logic [63:0] lo, input logic [63:0] hi,
                            input logic [4:0] len, input logic [7:0] wild,
                            input logic [31:0] size, input logic rev,
                            input logic [31:0] rel);
    wait_drained();
    reg_write(REG_PATTERN_LOW, lo);
    reg_write(REG_PATTERN_HIGH, hi);
    reg_write(REG_PATTERN_LENGTH, 64'(len));
    reg_write(REG_WILDCARD_BYTE, 64'(wild));
    reg_write(REG_SEARCH_COUNT, 64'(size));
    reg_write(REG_REVERSE_MODE, 64'(rev));
    reg_write(REG_RELATIVE_OFFSET, 64'(rel));
    cur_pat = {hi, lo};
    cur_len = len;
    cur_wild = wild;
  endtask

  task automatic random_config();
    logic [63:0] lo, hi;
    logic [4:0]  len;
    logic [7:0]  wild;
    logic [31:0] size, rel;
    int          sel;
    lo = {$urandom, $urandom};
    hi = {$urandom, $urandom};
    wild = 8'($urandom);
    for (int j = 0; j < 8; j++) begin
      if ($urandom_range(3) == 0) lo[8*j +: 8] = wild;
      if ($urandom_range(3) == 0) hi[8*j +: 8] = wild;
    end
    sel = $urandom_range(99);
    if (sel < 6) len = 5'd0;
    else if (sel < 14) len = 5'($urandom_range(31, 17));
    else if (sel < 70) len = 5'($urandom_range(6, 1));
    else len = 5'($urandom_range(16, 7));
    sel = $urandom_range(99);
    if (sel < 8) size = '0;
    else if (sel < 16) size = '1;
    else if (sel < 24) size = $urandom;
    else size = 32'($urandom_range(30, 1));
    sel = $urandom_range(99);
    if (sel < 10) rel = '0;
    else if (sel < 20) rel = '1;
    else rel = $urandom;
    set_config(lo, hi, len, wild, size, 1'($urandom_range(1)), rel);
  endtask

  task automatic random_stream();
    int n, at, plen;
    logic [7:0] p;
    n = $urandom_range(24, 1);
    plen = (cur_len > 16) ? 16 : int'(cur_len);
    for (int i = 0; i < n; i++) stream_buf[i] = 8'($urandom);
    repeat ($urandom_range(2)) begin
      if (plen > 0 && $urandom_range(9) < 7) begin
        at = $urandom_range(n - 1);
        for (int j = 0; j < plen; j++) begin
          p = cur_pat[8*j +: 8];
          if (at + j < n && p != cur_wild) stream_buf[at + j] = p;
        end
      end
    end
    for (int i = 0; i < n; i++) send_byte(stream_buf[i], i == n - 1);
  endtask

  initial begin : main
    int phase;
    sb = new();
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tlast = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    cur_pat = '0;
    cur_len = 5'd1;
    cur_wild = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // zero size at reset defaults
    send_byte(8'hFF, 1'b1);

    // forward hit at start, wildcard in the middle, bytes after the hit stay quiet
    set_config(64'h0000_0000_00CC_5AAA, 64'h0, 5'd3, 8'h5A, 32'd8, 1'b0, 32'hFFFF_FFFF);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h13, 1'b0);
    send_byte(8'hCC, 1'b0);
    send_byte(8'h77, 1'b1);

    // reverse hit at window start equal to size, on the last byte
    set_config(64'h0000_0000_00CC_5AAA, 64'h0, 5'd3, 8'h5A, 32'd1, 1'b1, 32'd0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h13, 1'b0);
    send_byte(8'hCC, 1'b1);

    // empty pattern
    set_config(64'h0, 64'h0, 5'd0, 8'h00, 32'hFFFF_FFFF, 1'b0, 32'd0);
    send_byte(8'hAA, 1'b1);

    // oversized length clamps to a full all-wildcard pattern
    set_config('1, '1, 5'd31, 8'hFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
    for (int i = 0; i < 16; i++) send_byte(8'($urandom), i == 15);

    phase = 0;
    while (bytes_sent < ITEMS) begin
      calm = (phase >= 8 && phase < 13);
      random_config();
      if (phase == 4 || phase == 15) begin
        hold_go++;
        repeat (60) send_byte(8'($urandom), 1'b1);
      end else begin
        repeat ($urandom_range(6, 2)) random_stream();
      end
      phase++;
    end
    calm = 1'b0;

    wait_drained();
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
